// ----- rtl/ytt_pkg.sv -----
// Shared constants and codes for the Young tableau transposition engine.
`default_nettype none
package ytt_pkg;

    // default store depth (numbers a tableau can hold)
    localparam int MAX_ENTRIES_DEF = 16;

    // width of the internal arithmetic on rows, columns and counts
    localparam int CALC_W = 8;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_GROW  = 2'd1,
        OP_SWAP  = 2'd2,
        OP_QUERY = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_REFUSED = 2'd1,
        ST_FULL    = 2'd2,
        ST_ABSENT  = 2'd3
    } status_t;

endpackage
`default_nettype wire

// ----- rtl/ytt_pos_mem.sv -----
// Position map memory: row and column of each number, two read ports, one write port.
`default_nettype none
module ytt_pos_mem #(
    parameter int  DEPTH = ytt_pkg::MAX_ENTRIES_DEF,
    localparam int AW    = $clog2(DEPTH),
    localparam int DW    = 2 * AW
) (
    input  wire logic          clk,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr_a,
    input  wire logic [AW-1:0] rd_addr_b,
    output logic      [DW-1:0] rd_data_a,
    output logic      [DW-1:0] rd_data_b,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [DW-1:0] wr_data
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data held until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule
`default_nettype wire

// ----- rtl/ytt_len_mem.sv -----
// Row length memory, one read port and one write port.
`default_nettype none
module ytt_len_mem #(
    parameter int  DEPTH = ytt_pkg::MAX_ENTRIES_DEF,
    localparam int AW    = $clog2(DEPTH),
    localparam int DW    = $clog2(DEPTH + 1)
) (
    input  wire logic          clk,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [DW-1:0] rd_data,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [DW-1:0] wr_data
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// ----- rtl/young_tableau_transposition_engine.sv -----
// Top level of the Young tableau transposition engine: control, counters and result register.
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+----------------------------------------
//  input    | in        | in_valid / in_ready   | op, row, number
//  result   | out       | out_valid / out_ready | status, swapped, distance, entry_count,
//           |           |                       | row_count, found_row, found_col,
//           |           |                       | row_length
//
// Steps: clear, grow and query pass through the synchronous read of the position and
// row length memories, then a step that computes and writes back. A transpose that
// swaps adds a further write step (S_SWAP2): the position memory has one write port,
// so the two exchanged entries are written in consecutive cycles.
// Reset clears the state, output valid and the entry and row counters; the memories
// get no clearing pass. A row length is valid only for rows below the row count, a
// position only for numbers up to the entry count, so stale memory data is never used.
// A stalled result register holds the engine in its compute step; the input side
// waits until the engine is back in idle.
`default_nettype none
module young_tableau_transposition_engine #(
    parameter int MAX_ENTRIES = ytt_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,

    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [1:0] op,
    input  wire logic [3:0] row,
    input  wire logic [4:0] number,

    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [1:0]      status,
    output logic            swapped,
    output logic [5:0]      distance,
    output logic [4:0]      entry_count,
    output logic [4:0]      row_count,
    output logic [3:0]      found_row,
    output logic [3:0]      found_col,
    output logic [4:0]      row_length
);

    localparam int AW = $clog2(MAX_ENTRIES);       // number slot / row / column index
    localparam int CW = $clog2(MAX_ENTRIES + 1);   // counts and lengths
    localparam int PW = 2 * AW;                    // packed {row, col}
    localparam int XW = ytt_pkg::CALC_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SWAP2
    } state_t;

    state_t          state_reg;
    logic [CW-1:0]   entries_reg;
    logic [CW-1:0]   rows_used_reg;
    ytt_pkg::op_t    op_reg;
    logic [3:0]      row_reg;
    logic [4:0]      num_reg;
    logic [AW-1:0]   grow_row_reg;
    logic [PW-1:0]   swap_data_reg;    // old position of t, written to slot of t+1

    logic            out_valid_reg;
    logic [1:0]      status_reg;
    logic            swapped_reg;
    logic [5:0]      distance_reg;
    logic [4:0]      entry_count_reg;
    logic [4:0]      row_count_reg;
    logic [3:0]      found_row_reg;
    logic [3:0]      found_col_reg;
    logic [4:0]      row_length_reg;

    // ------------------------------------------------------------------
    // Accept side: read addresses
    // ------------------------------------------------------------------
    logic            accept;
    logic [XW-1:0]   in_num_x;
    logic [XW-1:0]   in_num_m1_x;
    logic [XW-1:0]   in_row_x;
    logic [XW-1:0]   rows_x;
    logic [XW-1:0]   in_grow_row_x;
    logic [AW-1:0]   in_grow_row;
    logic [AW-1:0]   len_rd_addr;

    assign in_ready      = (state_reg == S_IDLE);
    assign accept        = in_valid && in_ready;
    assign in_num_x      = XW'(number);
    assign in_num_m1_x   = in_num_x - XW'(1);
    assign in_row_x      = XW'(row);
    assign rows_x        = XW'(rows_used_reg);
    // a row index at or past the row count opens a new row
    assign in_grow_row_x = (in_row_x < rows_x) ? in_row_x : rows_x;
    assign in_grow_row   = in_grow_row_x[AW-1:0];
    assign len_rd_addr   = (ytt_pkg::op_t'(op) == ytt_pkg::OP_GROW) ? in_grow_row
                                                                     : in_row_x[AW-1:0];

    logic [PW-1:0]   pos_rd_a;
    logic [PW-1:0]   pos_rd_b;
    logic [CW-1:0]   len_rd;
    logic            pos_wr_en;
    logic [AW-1:0]   pos_wr_addr;
    logic [PW-1:0]   pos_wr_data;
    logic            len_wr_en;
    logic [AW-1:0]   len_wr_addr;
    logic [CW-1:0]   len_wr_data;

    ytt_pos_mem #(
        .DEPTH (MAX_ENTRIES)
    ) u_pos_mem (
        .clk       (clk),
        .rd_en     (accept),
        .rd_addr_a (in_num_m1_x[AW-1:0]),
        .rd_addr_b (in_num_x[AW-1:0]),
        .rd_data_a (pos_rd_a),
        .rd_data_b (pos_rd_b),
        .wr_en     (pos_wr_en),
        .wr_addr   (pos_wr_addr),
        .wr_data   (pos_wr_data)
    );

    ytt_len_mem #(
        .DEPTH (MAX_ENTRIES)
    ) u_len_mem (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (len_rd_addr),
        .rd_data (len_rd),
        .wr_en   (len_wr_en),
        .wr_addr (len_wr_addr),
        .wr_data (len_wr_data)
    );

    // ------------------------------------------------------------------
    // Compute step: memory data is valid in S_EXEC
    // ------------------------------------------------------------------
    logic            go;
    logic [XW-1:0]   ent_x;
    logic [XW-1:0]   num_x;
    logic [XW-1:0]   row_x;
    logic            a_ok;
    logic            b_ok;
    logic [AW-1:0]   ar;
    logic [AW-1:0]   ac;
    logic [AW-1:0]   br;
    logic [AW-1:0]   bc;
    logic [XW-1:0]   ar_x;
    logic [XW-1:0]   ac_x;
    logic [XW-1:0]   br_x;
    logic [XW-1:0]   bc_x;
    logic [XW-1:0]   dist_x;
    logic            adjacent;
    logic            full;
    logic            new_row;
    logic [CW-1:0]   old_len;
    logic [CW-1:0]   new_len;
    logic [XW-1:0]   grow_row_x;
    logic [XW-1:0]   old_len_x;
    logic [XW-1:0]   rlen_x;
    logic [CW-1:0]   entries_next;
    logic [CW-1:0]   rows_used_next;
    logic [XW-1:0]   entries_next_x;
    logic [XW-1:0]   rows_next_x;

    logic [1:0]      res_status;
    logic            res_swapped;
    logic [5:0]      res_distance;
    logic [3:0]      res_found_row;
    logic [3:0]      res_found_col;
    logic [4:0]      res_row_length;

    assign go    = (state_reg == S_EXEC) && (!out_valid_reg || out_ready);
    assign ent_x = XW'(entries_reg);
    assign num_x = XW'(num_reg);
    assign row_x = XW'(row_reg);

    assign a_ok  = (num_x >= XW'(1)) && (num_x <= ent_x);
    assign b_ok  = ((num_x + XW'(1)) <= ent_x);

    assign ar    = pos_rd_a[PW-1:AW];
    assign ac    = pos_rd_a[AW-1:0];
    assign br    = pos_rd_b[PW-1:AW];
    assign bc    = pos_rd_b[AW-1:0];
    assign ar_x  = XW'(ar);
    assign ac_x  = XW'(ac);
    assign br_x  = XW'(br);
    assign bc_x  = XW'(bc);

    // content distance, wraps in the low six bits
    assign dist_x   = (bc_x - br_x) - (ac_x - ar_x);
    // t+1 directly right of t, or directly below it
    assign adjacent = ((ar_x == br_x) && (ac_x + XW'(1) == bc_x)) ||
                      ((ac_x == bc_x) && (ar_x + XW'(1) == br_x));

    assign full       = (ent_x >= XW'(MAX_ENTRIES));
    assign grow_row_x = XW'(grow_row_reg);
    assign new_row    = (grow_row_x == rows_x);
    assign old_len    = new_row ? '0 : len_rd;
    assign new_len    = old_len + CW'(1);
    assign old_len_x  = XW'(old_len);

    // slot index of t, one below the stored operand
    function automatic logic [AW-1:0] ar_dummy_addr(input logic [XW-1:0] n);
        logic [XW-1:0] m;
        m = n - XW'(1);
        return m[AW-1:0];
    endfunction

    always_comb
    begin
        entries_next   = entries_reg;
        rows_used_next = rows_used_reg;
        res_status     = ytt_pkg::ST_OK;
        res_swapped    = 1'b0;
        res_distance   = '0;
        res_found_row  = '0;
        res_found_col  = '0;
        res_row_length = '0;
        rlen_x         = '0;
        pos_wr_en      = 1'b0;
        pos_wr_addr    = entries_reg[AW-1:0];
        pos_wr_data    = {grow_row_reg, old_len[AW-1:0]};
        len_wr_en      = 1'b0;
        len_wr_addr    = grow_row_reg;
        len_wr_data    = new_len;

        if (go)
        begin
            unique case (op_reg)
                ytt_pkg::OP_CLEAR:
                begin
                    entries_next   = '0;
                    rows_used_next = '0;
                end
                ytt_pkg::OP_GROW:
                begin
                    if (full)
                    begin
                        res_status = ytt_pkg::ST_FULL;
                    end
                    else
                    begin
                        pos_wr_en      = 1'b1;
                        len_wr_en      = 1'b1;
                        entries_next   = entries_reg + CW'(1);
                        rows_used_next = rows_used_reg + CW'(new_row);
                        rlen_x         = XW'(new_len);
                        res_found_row  = grow_row_x[3:0];
                        res_found_col  = old_len_x[3:0];
                        res_row_length = rlen_x[4:0];
                    end
                end
                ytt_pkg::OP_SWAP:
                begin
                    if (!a_ok || !b_ok)
                    begin
                        res_status = ytt_pkg::ST_ABSENT;
                    end
                    else
                    begin
                        res_distance = dist_x[5:0];
                        if (adjacent)
                        begin
                            res_status = ytt_pkg::ST_REFUSED;
                        end
                        else
                        begin
                            // slot of t gets t+1's box now, the other slot next cycle
                            res_swapped = 1'b1;
                            pos_wr_en   = 1'b1;
                            pos_wr_addr = ar_dummy_addr(num_x);
                            pos_wr_data = pos_rd_b;
                        end
                    end
                end
                ytt_pkg::OP_QUERY:
                begin
                    if (a_ok)
                    begin
                        res_found_row = ar_x[3:0];
                        res_found_col = ac_x[3:0];
                    end
                    else
                    begin
                        res_status = ytt_pkg::ST_ABSENT;
                    end
                    if ((row_x < rows_x) && (row_x < XW'(MAX_ENTRIES)))
                    begin
                        rlen_x = XW'(len_rd);
                    end
                    res_row_length = rlen_x[4:0];
                end
                default:
                begin
                end
            endcase
        end
        else if (state_reg == S_SWAP2)
        begin
            pos_wr_en   = 1'b1;
            pos_wr_addr = num_x[AW-1:0];
            pos_wr_data = swap_data_reg;
        end
    end

    assign entries_next_x = XW'(entries_next);
    assign rows_next_x    = XW'(rows_used_next);

    // ------------------------------------------------------------------
    // State, counters and result register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            entries_reg   <= '0;
            rows_used_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // a new result may replace the one taken in the same cycle
            if (go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    if (go)
                    begin
                        entries_reg   <= entries_next;
                        rows_used_reg <= rows_used_next;
                        state_reg     <= res_swapped ? S_SWAP2 : S_IDLE;
                    end
                end
                S_SWAP2:
                begin
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg       <= ytt_pkg::op_t'(op);
            row_reg      <= row;
            num_reg      <= number;
            grow_row_reg <= in_grow_row;
        end
        if (go)
        begin
            swap_data_reg   <= pos_rd_a;
            status_reg      <= res_status;
            swapped_reg     <= res_swapped;
            distance_reg    <= res_distance;
            entry_count_reg <= entries_next_x[4:0];
            row_count_reg   <= rows_next_x[4:0];
            found_row_reg   <= res_found_row;
            found_col_reg   <= res_found_col;
            row_length_reg  <= res_row_length;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign swapped     = swapped_reg;
    assign distance    = distance_reg;
    assign entry_count = entry_count_reg;
    assign row_count   = row_count_reg;
    assign found_row   = found_row_reg;
    assign found_col   = found_col_reg;
    assign row_length  = row_length_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // an accepted transaction always goes through the compute step next
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_EXEC) && !in_ready)
        else $error("accepted transaction did not enter compute step");

    // counters stay within the store, never more rows than numbers
    a_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (XW'(entries_reg) <= XW'(MAX_ENTRIES)) && (rows_used_reg <= entries_reg))
        else $error("entry or row count out of range");

    // the second swap write follows only a result that reported an exchange
    a_swap2: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SWAP2) |-> out_valid_reg && $past(go) && swapped_reg)
        else $error("second position write without an exchange");

    // an exchange is only reported with ok status
    a_swap_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && swapped_reg) |-> (status_reg == ytt_pkg::ST_OK))
        else $error("exchange reported with non-ok status");

endmodule
`default_nettype wire
